/* hw/rtl/countdown_timer_with_keys_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the countdown timer with keys
// Clocked concurrent assertions, disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_WITH_KEYS_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_KEYS_ASSERT_SVH

// Plain clocked assertion with reset disable
`define CTK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent in a cycle, consequent checked in the cycle after
`define CTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ctk_pkg.sv */
// ---------------------------------------------------------------------------
// ctk_pkg
// Shared types and constants of the countdown timer with keys.
// ---------------------------------------------------------------------------
package ctk_pkg;

    localparam int SW_W      = 8;
    localparam int TENTHS_W  = 4;
    localparam int DIGIT_W   = 4;
    localparam int HUND_W    = 2;
    localparam int LED_W     = 10;
    localparam int KEYS_W    = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [LED_W-1:0]    LED_TICK_BIT  = 10'h200;
    localparam logic [LED_W-1:0]    LED_RUN_BIT   = 10'h100;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX    = 4'd9;

    // x / 10 == (x * 205) >> 11 for x below 1029
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef struct packed {
        logic [SW_W-1:0] switches;
        logic            key_load;
        logic            key_stop;
        logic            key_start;
        logic            tick;
    } t_ctk_item;

    typedef struct packed {
        logic [SW_W-1:0]     seconds;
        logic [TENTHS_W-1:0] tenths;
        logic                running;
        logic [LED_W-1:0]    led;
    } t_ctk_state;

    typedef struct packed {
        logic [SW_W-1:0]     seconds;
        logic [TENTHS_W-1:0] tenths;
    } t_ctk_time;

    typedef struct packed {
        logic [HUND_W-1:0]  hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
        logic [DIGIT_W-1:0] tenths;
    } t_ctk_digits;

endpackage

/* hw/rtl/ctk_core.sv */
// ---------------------------------------------------------------------------
// ctk_core
// Timer state and its update for one polled item: tick step, then key edges.
// ---------------------------------------------------------------------------
module ctk_core
    import ctk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_ctk_item  i_item,
    output t_ctk_state o_next
);

    logic [SW_W-1:0]     r_seconds, n_seconds;
    logic [TENTHS_W-1:0] r_tenths,  n_tenths;
    logic                r_running, n_running;
    logic [LED_W-1:0]    r_led,     n_led;
    logic [KEYS_W-1:0]   r_prev_keys, n_prev_keys;

    always_comb begin
        logic [KEYS_W-1:0] rising;
        n_prev_keys = {i_item.key_load, i_item.key_stop, i_item.key_start};
        rising      = n_prev_keys & ~r_prev_keys;
        n_seconds   = r_seconds;
        n_tenths    = r_tenths;
        n_running   = r_running;
        n_led       = r_led;

        if (i_item.tick && r_running) begin
            n_led = n_led ^ LED_TICK_BIT;
            if (n_tenths == '0) begin
                if (n_seconds != '0) begin
                    n_seconds = n_seconds - SW_W'(1);
                    n_tenths  = TENTHS_MAX;
                end
            end else begin
                n_tenths = n_tenths - TENTHS_W'(1);
            end
            if (n_tenths == '0 && n_seconds == '0) begin
                n_running = 1'b0;
                n_led     = n_led & ~LED_RUN_BIT;
            end
        end

        if (rising[0] && (n_seconds != '0 || n_tenths != '0)) begin
            n_running = 1'b1;
            n_led     = n_led | LED_RUN_BIT;
        end
        if (rising[1]) begin
            n_running = 1'b0;
            n_led     = n_led & ~LED_RUN_BIT;
        end
        if (rising[2]) begin
            n_seconds = i_item.switches;
            n_tenths  = '0;
            n_led     = {{(LED_W-SW_W){1'b0}}, i_item.switches};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds   <= '0;
            r_tenths    <= '0;
            r_running   <= 1'b0;
            r_led       <= '0;
            r_prev_keys <= '0;
        end else if (i_step) begin
            r_seconds   <= n_seconds;
            r_tenths    <= n_tenths;
            r_running   <= n_running;
            r_led       <= n_led;
            r_prev_keys <= n_prev_keys;
        end
    end

    assign o_next = '{seconds: n_seconds, tenths: n_tenths, running: n_running, led: n_led};

endmodule

/* hw/rtl/ctk_bcd.sv */
// ---------------------------------------------------------------------------
// ctk_bcd
// Splits the remaining time into decimal digits by reciprocal multiplies.
// ---------------------------------------------------------------------------
module ctk_bcd
    import ctk_pkg::*;
(
    input  t_ctk_time   i_time,
    output t_ctk_digits o_digits
);

    logic [15:0] prod_lo;
    logic [4:0]  quot_lo;
    logic [12:0] prod_hi;
    logic [1:0]  quot_hi;
    logic [8:0]  lo_times10;
    logic [4:0]  hi_times10;

    always_comb begin
        prod_lo    = 16'(i_time.seconds) * 16'(DIV10_MUL);
        quot_lo    = 5'(prod_lo >> DIV10_SHIFT);
        prod_hi    = 13'(quot_lo) * 13'(DIV10_MUL);
        quot_hi    = 2'(prod_hi >> DIV10_SHIFT);
        lo_times10 = 9'(quot_lo) * 9'd10;
        hi_times10 = 5'(quot_hi) * 5'd10;

        o_digits.tenths   = i_time.tenths;
        o_digits.units    = 4'(9'(i_time.seconds) - lo_times10);
        o_digits.tens     = 4'(quot_lo - hi_times10);
        o_digits.hundreds = quot_hi;
    end

endmodule

/* hw/rtl/countdown_timer_with_keys.sv */
// ---------------------------------------------------------------------------
// countdown_timer_with_keys
// Countdown timer in seconds and tenths driven by a tick flag and three keys.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one polled input per beat: tick flag, the levels of
//   the start, stop and load keys and the 8-bit switch value.
//   Master stream returns one beat per input beat: the remaining time as four
//   decimal digits, the running flag and the 10-bit LED word.
//   Path: input register, then result register. Throughput: one beat per
//   cycle, sustained while the receiver keeps tready high; the timer state
//   is updated in the same cycle as the result register is loaded.
//   Stalls: when the receiver holds tready low the result stays put and the
//   input register, if empty, still takes one more beat; after that s_tready falls
//   until the result drains. Key edges are taken between accepted beats
//   only, so stalling never creates or loses an edge.
//   Reset: synchronous, active low; time zero, stopped, LEDs dark, all keys
//   seen as released, both registers emptied.
// ---------------------------------------------------------------------------
module countdown_timer_with_keys
    import ctk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [0] tick, [1] key_start, [2] key_stop, [3] key_load, [11:4] switches
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [3:0] tenths_digit, [7:4] units_digit, [11:8] tens_digit,
    // [13:12] hundreds_digit, [14] is_running, [24:15] led_word
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int ITEM_W = $bits(t_ctk_item);
    localparam int RES_W  = $bits(t_ctk_digits) + 1 + LED_W;

    logic        r_in_valid;
    t_ctk_item   r_item;
    logic        r_out_valid;
    logic [RES_W-1:0] r_result;

    logic        advance;
    logic        step;
    t_ctk_state  next_state;
    t_ctk_time   remaining;
    t_ctk_digits digits;

    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= t_ctk_item'(i_s_tdata[ITEM_W-1:0]);
        end
    end

    ctk_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_next  (next_state)
    );

    assign remaining = '{seconds: next_state.seconds, tenths: next_state.tenths};

    ctk_bcd u_bcd (
        .i_time   (remaining),
        .o_digits (digits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= {next_state.led, next_state.running, digits};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, r_result};

endmodule

/* hw/rtl/ctk_checker.sv */
// ---------------------------------------------------------------------------
// ctk_checker
// Port-level checks on the result stream of the countdown timer.
// ---------------------------------------------------------------------------
`include "countdown_timer_with_keys_assert.svh"

module ctk_checker
    import ctk_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // stalled result beat must hold
    `CTK_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed under stall")

    // every shown digit is decimal
    `CTK_ASSERT(a_digit_range, i_clk, i_rst_n, !o_m_tvalid || (o_m_tdata[3:0] <= 4'd9 && o_m_tdata[7:4] <= 4'd9 && o_m_tdata[11:8] <= 4'd9 && o_m_tdata[13:12] <= 2'd2), "digit out of range")

    // padding above the LED word stays clear
    `CTK_ASSERT(a_pad_zero, i_clk, i_rst_n, !o_m_tvalid || o_m_tdata[31:25] == 7'd0, "padding bits set")

    // input side only stalls behind a result beat the receiver is holding
    `CTK_ASSERT(a_ready_stall, i_clk, i_rst_n, o_s_tready || (o_m_tvalid && !i_m_tready), "input stalled with no waiting result")

endmodule

bind countdown_timer_with_keys ctk_checker u_ctk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
